// ===== rtl/igtf_pkg.sv =====
package igtf_pkg;

  localparam int unsigned BufferDepthDefault = 32;
  localparam int unsigned MaxResults         = 32;

  localparam int unsigned OpWidth       = 2;
  localparam int unsigned ByteWidth     = 8;
  localparam int unsigned CountWidth    = 6;
  localparam int unsigned GapWidth      = 16;
  localparam int unsigned LimitWidth    = 6;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 16;

  localparam logic [GapWidth-1:0]   GapReset   = 16'd1000;
  localparam logic [LimitWidth-1:0] LimitReset = 6'd33;
  localparam logic [GapWidth-1:0]   TickMax    = 16'hFFFF;

  localparam logic [ByteWidth-1:0] CharSpace = 8'h20;
  localparam logic [ByteWidth-1:0] CharTilde = 8'h7E;
  localparam logic [ByteWidth-1:0] CharTab   = 8'h09;

  typedef enum logic [OpWidth-1:0] {
    OP_APPEND = 2'd0,
    OP_TICK   = 2'd1,
    OP_TAKE   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_IDLE_GAP   = 2'd0,
    REG_TEXT_LIMIT = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } state_t;

  // Address fields sized for the largest buffer; the store slices them.
  typedef struct packed {
    logic                  wr_en;
    logic [CountWidth-1:0] wr_addr;
    logic [ByteWidth-1:0]  wr_data;
    logic                  rd_en;
    logic [CountWidth-1:0] rd_addr;
  } mem_req_t;

  function automatic logic passes_filter(input logic [ByteWidth-1:0] b);
    passes_filter = ((b >= CharSpace) && (b <= CharTilde)) || (b == CharTab);
  endfunction

endpackage

// ===== rtl/igtf_in_if.sv =====
interface igtf_in_if;
  logic                           valid;
  logic                           ready;
  logic [igtf_pkg::OpWidth-1:0]   operation;
  logic [igtf_pkg::ByteWidth-1:0] data_byte;

  modport source(output valid, operation, data_byte, input ready);
  modport sink(input valid, operation, data_byte, output ready);
endinterface

// ===== rtl/igtf_out_if.sv =====
interface igtf_out_if;
  logic                            valid;
  logic                            ready;
  logic                            byte_valid;
  logic [igtf_pkg::ByteWidth-1:0]  text_byte;
  logic                            last;
  logic                            text_found;
  logic                            flush_ready;
  logic                            byte_dropped;
  logic [igtf_pkg::CountWidth-1:0] buffered_count;

  modport source(output valid, byte_valid, text_byte, last, text_found, flush_ready,
                 byte_dropped, buffered_count, input ready);
  modport sink(input valid, byte_valid, text_byte, last, text_found, flush_ready,
               byte_dropped, buffered_count, output ready);
endinterface

// ===== rtl/igtf_cfg_if.sv =====
interface igtf_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [igtf_pkg::CfgIndexWidth-1:0] index;
  logic [igtf_pkg::CfgDataWidth-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/idle_gap_text_framer_top.sv =====
// Idle-gap text framer. Received bytes (append) are stored in a buffer of BUFFER_DEPTH
// entries; a byte that finds the buffer full is dropped and flagged. Tick words advance
// an idle counter (saturating at 65535) that each stored byte clears, and every result
// reports flush_ready once the buffer is nonempty and the idle count has reached
// idle_gap_ticks. A take word drains the buffer as text: only 0x20..0x7E and tab pass,
// at most text_limit-1 of them (and at most 32), the final one marked last; with no
// passing byte one empty result is given. Append, tick and the unused code give their
// result in the output register on the next cycle. A take holds the input while the
// buffered bytes are scanned: each byte is a read of the buffer memory read port
// followed by a filter step, and a stalled output holds the take longer. Configuration
// writes are taken in any cycle; register index 0 is idle_gap_ticks, index 1 is text_limit.
module idle_gap_text_framer_top #(
  parameter int unsigned BUFFER_DEPTH = igtf_pkg::BufferDepthDefault
) (
  input logic         clk,
  input logic         rst,
  igtf_in_if.sink     rx,
  igtf_out_if.source  tx,
  igtf_cfg_if.sink    cfg
);

  igtf_pkg::mem_req_t             mem_req;
  logic [igtf_pkg::ByteWidth-1:0] rd_data;

  igtf_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .tx      (tx),
    .cfg     (cfg),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  igtf_store #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

endmodule

// ===== rtl/igtf_store.sv =====
module igtf_store #(
  parameter int unsigned BUFFER_DEPTH = igtf_pkg::BufferDepthDefault
) (
  input  logic                           clk,
  input  igtf_pkg::mem_req_t             mem_req,
  output logic [igtf_pkg::ByteWidth-1:0] rd_data
);

  localparam int unsigned AddrWidth = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic [igtf_pkg::ByteWidth-1:0] mem [BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr[AddrWidth-1:0]] <= mem_req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd_data <= mem[mem_req.rd_addr[AddrWidth-1:0]];
    end
  end

endmodule

// ===== rtl/igtf_ctrl.sv =====
module igtf_ctrl #(
  parameter int unsigned BUFFER_DEPTH = igtf_pkg::BufferDepthDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  igtf_in_if.sink                        rx,
  igtf_out_if.source                     tx,
  igtf_cfg_if.sink                       cfg,
  output igtf_pkg::mem_req_t             mem_req,
  input  logic [igtf_pkg::ByteWidth-1:0] rd_data
);

  localparam int unsigned CW = igtf_pkg::CountWidth;
  localparam logic [CW-1:0] DepthCount = CW'(BUFFER_DEPTH);
  localparam logic [CW:0]   ResultCap  = (CW+1)'(igtf_pkg::MaxResults);

  igtf_pkg::state_t state, state_next;

  logic [CW-1:0]                      stored_count, stored_count_next;
  logic [igtf_pkg::GapWidth-1:0]      idle_ticks, idle_ticks_next;
  logic [igtf_pkg::GapWidth-1:0]      gap_limit;
  logic [igtf_pkg::LimitWidth-1:0]    text_limit;
  logic [CW-1:0]                      scan_idx, scan_idx_next;
  logic [CW-1:0]                      scan_count, scan_count_next;
  logic [CW-1:0]                      emit_count, emit_count_next;
  logic                               pend_valid, pend_valid_next;
  logic [igtf_pkg::ByteWidth-1:0]     pend_byte, pend_byte_next;

  logic                               out_valid;
  logic                               out_free;
  logic                               accept;
  igtf_pkg::op_t                      op;

  logic                               res_load;
  logic                               res_byte_valid;
  logic [igtf_pkg::ByteWidth-1:0]     res_byte;
  logic                               res_last;
  logic                               res_found;
  logic                               res_dropped;
  logic                               res_flush;

  logic [CW-1:0]                      emit_after;
  logic                               more_scan;

  assign out_free = !out_valid || tx.ready;
  assign rx.ready = (state == igtf_pkg::ST_IDLE) && out_free;
  assign accept   = rx.valid && rx.ready;
  assign op       = igtf_pkg::op_t'(rx.operation);
  assign cfg.ready = 1'b1;

  // Count including the byte under check, if it passes.
  assign emit_after = igtf_pkg::passes_filter(rd_data) ? emit_count + CW'(1) : emit_count;
  assign more_scan  = (({1'b0, scan_idx} + (CW+1)'(1)) < {1'b0, scan_count}) &&
                      (({1'b0, emit_after} + (CW+1)'(1)) < (CW+1)'(text_limit)) &&
                      ({1'b0, emit_after} < ResultCap);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= igtf_pkg::ST_IDLE;
      stored_count <= '0;
      idle_ticks   <= '0;
      pend_valid   <= 1'b0;
    end else begin
      state        <= state_next;
      stored_count <= stored_count_next;
      idle_ticks   <= idle_ticks_next;
      pend_valid   <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx   <= scan_idx_next;
    scan_count <= scan_count_next;
    emit_count <= emit_count_next;
    pend_byte  <= pend_byte_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit  <= igtf_pkg::GapReset;
      text_limit <= igtf_pkg::LimitReset;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        igtf_pkg::REG_IDLE_GAP:   gap_limit  <= cfg.data;
        igtf_pkg::REG_TEXT_LIMIT: text_limit <= cfg.data[igtf_pkg::LimitWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next        = state;
    stored_count_next = stored_count;
    idle_ticks_next   = idle_ticks;
    scan_idx_next     = scan_idx;
    scan_count_next   = scan_count;
    emit_count_next   = emit_count;
    pend_valid_next   = pend_valid;
    pend_byte_next    = pend_byte;
    mem_req           = '0;
    res_load          = 1'b0;
    res_byte_valid    = 1'b0;
    res_byte          = '0;
    res_last          = 1'b1;
    res_found         = 1'b0;
    res_dropped       = 1'b0;

    unique case (state)
      igtf_pkg::ST_IDLE: begin
        if (accept) begin
          case (op)
            igtf_pkg::OP_APPEND: begin
              res_load = 1'b1;
              if (stored_count < DepthCount) begin
                mem_req.wr_en     = 1'b1;
                mem_req.wr_addr   = stored_count;
                mem_req.wr_data   = rx.data_byte;
                stored_count_next = stored_count + CW'(1);
                idle_ticks_next   = '0;
              end else begin
                res_dropped = 1'b1;
              end
            end
            igtf_pkg::OP_TICK: begin
              res_load = 1'b1;
              if (idle_ticks != igtf_pkg::TickMax) begin
                idle_ticks_next = idle_ticks + igtf_pkg::GapWidth'(1);
              end
            end
            igtf_pkg::OP_TAKE: begin
              // buffer reads as empty for every result of the take
              stored_count_next = '0;
              scan_count_next   = stored_count;
              scan_idx_next     = '0;
              emit_count_next   = '0;
              pend_valid_next   = 1'b0;
              if ((stored_count != '0) && (text_limit > igtf_pkg::LimitWidth'(1))) begin
                state_next = igtf_pkg::ST_READ;
              end else begin
                state_next = igtf_pkg::ST_FINISH;
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      igtf_pkg::ST_READ: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = scan_idx;
        state_next      = igtf_pkg::ST_CHECK;
      end
      igtf_pkg::ST_CHECK: begin
        // A pending char goes out only once a later one proves it is not last.
        if (!(igtf_pkg::passes_filter(rd_data) && pend_valid && !out_free)) begin
          if (igtf_pkg::passes_filter(rd_data)) begin
            if (pend_valid) begin
              res_load       = 1'b1;
              res_byte_valid = 1'b1;
              res_byte       = pend_byte;
              res_last       = 1'b0;
              res_found      = 1'b1;
            end
            pend_valid_next = 1'b1;
            pend_byte_next  = rd_data;
          end
          emit_count_next = emit_after;
          scan_idx_next   = scan_idx + CW'(1);
          state_next      = more_scan ? igtf_pkg::ST_READ : igtf_pkg::ST_FINISH;
        end
      end
      igtf_pkg::ST_FINISH: begin
        if (out_free) begin
          res_load        = 1'b1;
          res_byte_valid  = pend_valid;
          res_byte        = pend_valid ? pend_byte : '0;
          res_found       = pend_valid;
          pend_valid_next = 1'b0;
          state_next      = igtf_pkg::ST_IDLE;
        end
      end
      default: state_next = igtf_pkg::ST_IDLE;
    endcase

    res_flush = (stored_count_next != '0) && (idle_ticks_next >= gap_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      tx.byte_valid     <= res_byte_valid;
      tx.text_byte      <= res_byte;
      tx.last           <= res_last;
      tx.text_found     <= res_found;
      tx.flush_ready    <= res_flush;
      tx.byte_dropped   <= res_dropped;
      tx.buffered_count <= stored_count_next;
    end
  end

  assign tx.valid = out_valid;

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (rx.valid && rx.ready) |-> (state == igtf_pkg::ST_IDLE))
    else $error("input word accepted while a take is in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= DepthCount)
    else $error("stored count beyond buffer depth");

  a_take_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == igtf_pkg::OP_TAKE)) |=> (stored_count == '0))
    else $error("take did not empty the buffer");

  a_emit_cap: assert property (@(posedge clk) disable iff (rst)
    (state == igtf_pkg::ST_CHECK) |-> ({1'b0, emit_count} < ResultCap))
    else $error("take scan ran past the result cap");

  a_flush_nonempty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tx.flush_ready) |-> (tx.buffered_count != '0))
    else $error("flush reported on an empty buffer");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !tx.ready) |-> !res_load)
    else $error("result register overwritten while stalled");

endmodule

// ===== sim/idle_gap_text_framer_top_test.sv =====
typedef struct packed {
  logic                            byte_valid;
  logic [igtf_pkg::ByteWidth-1:0]  text_byte;
  logic                            last;
  logic                            text_found;
  logic                            flush_ready;
  logic                            byte_dropped;
  logic [igtf_pkg::CountWidth-1:0] buffered_count;
} framer_word_t;

class line_framer_book;
  logic [igtf_pkg::ByteWidth-1:0]  held_bytes[igtf_pkg::BufferDepthDefault];
  int unsigned                     held_count;
  logic [igtf_pkg::GapWidth-1:0]   idle_count;
  logic [igtf_pkg::GapWidth-1:0]   gap_ticks;
  logic [igtf_pkg::LimitWidth-1:0] char_limit;
  framer_word_t                    due_words[$];
  int unsigned                     mismatches;
  int unsigned                     words_seen;
  int unsigned                     frames_with_text;
  int unsigned                     dropped_seen;
  int unsigned                     flush_seen;

  function new();
    held_count = 0;
    idle_count = '0;
    gap_ticks  = igtf_pkg::GapReset;
    char_limit = igtf_pkg::LimitReset;
  endfunction

  function void write_reg(logic [igtf_pkg::CfgIndexWidth-1:0] idx,
                          logic [igtf_pkg::CfgDataWidth-1:0] value);
    case (idx)
      igtf_pkg::REG_IDLE_GAP:   gap_ticks = value[igtf_pkg::GapWidth-1:0];
      igtf_pkg::REG_TEXT_LIMIT: char_limit = value[igtf_pkg::LimitWidth-1:0];
      default: ;
    endcase
  endfunction

  // status fields reflect the state after the word
  function framer_word_t status(logic valid, logic [igtf_pkg::ByteWidth-1:0] ch, logic last,
                                logic found, logic dropped);
    framer_word_t w;
    w.byte_valid     = valid;
    w.text_byte      = ch;
    w.last           = last;
    w.text_found     = found;
    w.flush_ready    = (held_count != 0) && (idle_count >= gap_ticks);
    w.byte_dropped   = dropped;
    w.buffered_count = held_count[igtf_pkg::CountWidth-1:0];
    return w;
  endfunction

  function void absorb_word(igtf_pkg::op_t op, logic [igtf_pkg::ByteWidth-1:0] data);
    logic [igtf_pkg::ByteWidth-1:0] text[$];
    int unsigned                    i;
    int unsigned                    k;
    case (op)
      igtf_pkg::OP_APPEND: begin
        if (held_count < igtf_pkg::BufferDepthDefault) begin
          held_bytes[held_count] = data;
          held_count++;
          idle_count = '0;
          due_words.push_back(status(1'b0, '0, 1'b1, 1'b0, 1'b0));
        end else begin
          due_words.push_back(status(1'b0, '0, 1'b1, 1'b0, 1'b1));
        end
      end
      igtf_pkg::OP_TICK: begin
        if (idle_count != igtf_pkg::TickMax) idle_count++;
        due_words.push_back(status(1'b0, '0, 1'b1, 1'b0, 1'b0));
      end
      igtf_pkg::OP_TAKE: begin
        // room for a terminator: at most char_limit-1 characters
        for (i = 0; i < held_count && text.size() + 1 < int'(char_limit) &&
             text.size() < igtf_pkg::MaxResults; i++) begin
          if ((held_bytes[i] >= igtf_pkg::CharSpace && held_bytes[i] <= igtf_pkg::CharTilde) ||
              held_bytes[i] == igtf_pkg::CharTab)
            text.push_back(held_bytes[i]);
        end
        held_count = 0;
        if (text.size() == 0) begin
          due_words.push_back(status(1'b0, '0, 1'b1, 1'b0, 1'b0));
        end else begin
          for (k = 0; k < text.size(); k++)
            due_words.push_back(status(1'b1, text[k], k + 1 == text.size(), 1'b1, 1'b0));
        end
      end
      default: due_words.push_back(status(1'b0, '0, 1'b1, 1'b0, 1'b0));
    endcase
  endfunction

  function void field_check(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function void match_word(framer_word_t got);
    framer_word_t want;
    words_seen++;
    if (due_words.size() == 0) begin
      $error("result word with nothing pending: %h", got);
      mismatches++;
      return;
    end
    want = due_words.pop_front();
    field_check("byte_valid", 16'(want.byte_valid), 16'(got.byte_valid));
    field_check("text_byte", 16'(want.text_byte), 16'(got.text_byte));
    field_check("last", 16'(want.last), 16'(got.last));
    field_check("text_found", 16'(want.text_found), 16'(got.text_found));
    field_check("flush_ready", 16'(want.flush_ready), 16'(got.flush_ready));
    field_check("byte_dropped", 16'(want.byte_dropped), 16'(got.byte_dropped));
    field_check("buffered_count", 16'(want.buffered_count), 16'(got.buffered_count));
    if (got.text_found === 1'b1 && got.last === 1'b1) frames_with_text++;
    if (got.byte_dropped === 1'b1) dropped_seen++;
    if (got.flush_ready === 1'b1) flush_seen++;
  endfunction
endclass

module idle_gap_text_framer_top_test;

  localparam logic [igtf_pkg::CfgIndexWidth-1:0] RegSpareLow  = 2'd2;
  localparam logic [igtf_pkg::CfgIndexWidth-1:0] RegSpareHigh = 2'd3;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned SettleCycles = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  igtf_in_if  in_if();
  igtf_out_if out_if();
  igtf_cfg_if cfg_if();

  idle_gap_text_framer_top u_top (
    .clk (clk),
    .rst (rst),
    .rx  (in_if),
    .tx  (out_if),
    .cfg (cfg_if)
  );

  line_framer_book book;
  framer_word_t    seen_word;
  int unsigned     tx_idle_pct = 0;
  int unsigned     rx_idle_pct = 0;
  int unsigned     words_sent = 0;
  int unsigned     settings_used = 0;
  int unsigned     hold_asked = 0;
  int unsigned     hold_served = 0;
  int unsigned     hold_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #24_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver: random back-pressure plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        seen_word = '{byte_valid: out_if.byte_valid, text_byte: out_if.text_byte,
                      last: out_if.last, text_found: out_if.text_found,
                      flush_ready: out_if.flush_ready, byte_dropped: out_if.byte_dropped,
                      buffered_count: out_if.buffered_count};
        book.match_word(seen_word);
      end
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // valid stays high across back-to-back words; lowered for an idle cycle or a drain
  task automatic send_word(igtf_pkg::op_t op, logic [igtf_pkg::ByteWidth-1:0] data);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.data_byte <= data;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    book.absorb_word(op, data);
    words_sent++;
  endtask

  task automatic write_reg(logic [igtf_pkg::CfgIndexWidth-1:0] idx,
                           logic [igtf_pkg::CfgDataWidth-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    book.write_reg(idx, value);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (book.due_words.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // upper data bits of the limit word are junk the block must mask off
  task automatic apply_settings(logic [igtf_pkg::GapWidth-1:0] gap,
                                logic [igtf_pkg::LimitWidth-1:0] limit);
    drain();
    write_reg(igtf_pkg::REG_IDLE_GAP, gap);
    write_reg(igtf_pkg::REG_TEXT_LIMIT, {10'($urandom), limit});
    if ($urandom_range(2) == 0) begin
      write_reg(RegSpareLow, 16'($urandom));
      write_reg(RegSpareHigh, 16'($urandom));
    end
    cfg_if.valid <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  function automatic logic [igtf_pkg::ByteWidth-1:0] line_byte();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return 8'($urandom_range(32, 126));
    if (pick < 80) return ($urandom_range(1) == 0) ? igtf_pkg::CharTab : 8'h0D;
    return 8'($urandom);
  endfunction

  task automatic random_settings();
    logic [igtf_pkg::GapWidth-1:0]   gap;
    logic [igtf_pkg::LimitWidth-1:0] limit;
    case ($urandom_range(5))
      0:       gap = '0;
      1:       gap = igtf_pkg::TickMax;
      2:       gap = 16'($urandom);
      default: gap = 16'($urandom_range(1, 5));
    endcase
    case ($urandom_range(7))
      0:       limit = '0;
      1:       limit = 6'd1;
      2:       limit = 6'd2;
      3:       limit = 6'h3F;
      4:       limit = 6'($urandom_range(3, 32));
      default: limit = igtf_pkg::LimitReset;
    endcase
    apply_settings(gap, limit);
  endtask

  // mostly a frame: bytes, some idle ticks, then a take; the rest is noise
  task automatic frame_burst();
    int unsigned n_bytes;
    if ($urandom_range(99) < 80) begin
      n_bytes = ($urandom_range(4) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 10);
      repeat (n_bytes) send_word(igtf_pkg::OP_APPEND, line_byte());
      repeat ($urandom_range(0, 6)) send_word(igtf_pkg::OP_TICK, 8'($urandom));
      if ($urandom_range(3) == 0) send_word(igtf_pkg::OP_APPEND, line_byte());
      send_word(igtf_pkg::OP_TAKE, 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4))
        send_word(igtf_pkg::op_t'($urandom_range(3)), 8'($urandom));
    end
  endtask

  task automatic random_phase(int unsigned quota);
    int unsigned start;
    int unsigned chunk;
    start = words_sent;
    while (words_sent - start < quota) begin
      random_settings();
      chunk = words_sent;
      while (words_sent - chunk < 25) frame_burst();
    end
  endtask

  initial begin
    book = new();
    in_if.valid      <= 1'b0;
    in_if.operation  <= igtf_pkg::OP_NONE;
    in_if.data_byte  <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= igtf_pkg::REG_IDLE_GAP;
    cfg_if.data      <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: empty take, filter edges, control characters
    send_word(igtf_pkg::OP_TAKE, 8'h00);
    send_word(igtf_pkg::OP_APPEND, 8'h00);
    send_word(igtf_pkg::OP_APPEND, igtf_pkg::CharTab);
    send_word(igtf_pkg::OP_APPEND, igtf_pkg::CharSpace);
    send_word(igtf_pkg::OP_APPEND, igtf_pkg::CharTilde);
    send_word(igtf_pkg::OP_APPEND, 8'h7F);
    send_word(igtf_pkg::OP_APPEND, 8'hFF);
    send_word(igtf_pkg::OP_APPEND, 8'h0D);
    send_word(igtf_pkg::OP_APPEND, 8'h0A);
    send_word(igtf_pkg::OP_APPEND, 8'h1F);
    send_word(igtf_pkg::OP_APPEND, 8'h41);
    send_word(igtf_pkg::OP_NONE, 8'hFF);
    send_word(igtf_pkg::OP_TICK, 8'hAA);
    send_word(igtf_pkg::OP_TAKE, 8'h55);

    // zero gap, zero limit: take only clears
    apply_settings('0, '0);
    send_word(igtf_pkg::OP_APPEND, 8'h41);
    send_word(igtf_pkg::OP_TAKE, 8'h00);
    // limit 2 gives a single character; the ticks meet the gap before the take
    apply_settings(16'd2, 6'd2);
    send_word(igtf_pkg::OP_APPEND, 8'h61);
    send_word(igtf_pkg::OP_APPEND, 8'h62);
    send_word(igtf_pkg::OP_TICK, 8'h00);
    send_word(igtf_pkg::OP_TICK, 8'h00);
    send_word(igtf_pkg::OP_TAKE, 8'h00);
    // limit 1 leaves no room for any character
    apply_settings(16'd2, 6'd1);
    send_word(igtf_pkg::OP_APPEND, 8'h63);
    send_word(igtf_pkg::OP_TAKE, 8'h00);

    tx_idle_pct = 12;
    rx_idle_pct = 76;
    random_phase(60);

    drain();
    tx_idle_pct = 76;
    rx_idle_pct = 12;
    random_phase(60);

    drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_asked++;
    random_phase(60);

    // the largest gap stays out of reach of a short idle
    apply_settings(igtf_pkg::TickMax, igtf_pkg::LimitReset);
    send_word(igtf_pkg::OP_APPEND, 8'h5A);
    repeat (5) send_word(igtf_pkg::OP_TICK, 8'h00);
    send_word(igtf_pkg::OP_TAKE, 8'h00);

    drain();
    $display("covered %0d input words and %0d result words under %0d register settings",
             words_sent, book.words_seen, settings_used);
    $display("%0d text frames, %0d dropped bytes, %0d results with flush due",
             book.frames_with_text, book.dropped_seen, book.flush_seen);
    if (book.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== idle_gap_text_framer_top.f =====
rtl/igtf_pkg.sv
rtl/igtf_in_if.sv
rtl/igtf_out_if.sv
rtl/igtf_cfg_if.sv
rtl/igtf_store.sv
rtl/igtf_ctrl.sv
rtl/idle_gap_text_framer_top.sv
sim/idle_gap_text_framer_top_test.sv
